FILE: design/nose_hoover_chain_update_assert.svh
// assertion macros for the chain thermostat sequencer
`ifndef NOSE_HOOVER_CHAIN_UPDATE_ASSERT_SVH
`define NOSE_HOOVER_CHAIN_UPDATE_ASSERT_SVH

// condition must never hold
`define NHC_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("nhc assertion failed");

// antecedent implies consequent in the same cycle
`define NHC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nhc assertion failed");

`endif

FILE: design/nhc_pkg.sv
// types, codes and fixed point helpers for the chain thermostat
package nhc_pkg;

    localparam int FRAC = 24;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    localparam logic [2:0] CFG_TARGET_KT    = 3'd0;
    localparam logic [2:0] CFG_COUPLING     = 3'd1;
    localparam logic [2:0] CFG_TIME_STEP    = 3'd2;
    localparam logic [2:0] CFG_DOF          = 3'd3;
    localparam logic [2:0] CFG_ACTIVE_LINKS = 3'd4;

    typedef struct packed {
        logic [46:0] target_kt;
        logic [24:0] coupling_freq;
        logic [31:0] time_step;
        logic [23:0] degrees_of_freedom;
    } t_cfg;

    typedef enum logic [3:0] {
        OPD_KTT, OPD_DQ, OPD_CI, OPD_CN, OPD_P,
        OPD_W2, OPD_DT, OPD_F, OPD_R, OPD_Z
    } t_opnd;

    typedef enum logic {
        DSR_TGT, DSR_DOF
    } t_dsr;

    typedef enum logic [3:0] {
        ALU_NONE, ALU_F_SET, ALU_F_RT, ALU_F_SUB, ALU_CI_ADD, ALU_R_SET,
        ALU_Z_ADD, ALU_EM_SET, ALU_EM_ADD, ALU_EF_SET, ALU_EF_ADD
    } t_alu;

    typedef struct packed {
        logic  mul_start;
        t_opnd mul_a;
        t_opnd mul_b;
        logic  div_start;
        t_opnd div_a;
        t_dsr  div_b;
        t_alu  alu;
        logic  rd;
        logic  ld_ci;
        logic  ld_cn;
        logic  ld_z;
        logic  addr_nxt;
        logic  wr_c;
        logic  wr_z;
        logic  kt_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_dp_sts;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RDC, ST_LDC, ST_LDN, ST_MUL_KD, ST_F_SET, ST_F_RT,
        ST_MUL_CC, ST_DIV_PT, ST_MUL_PW, ST_F_SUB, ST_MUL_DF, ST_CI_ADD,
        ST_WR_C, ST_DIV_CT, ST_DIV_PD, ST_MUL_QW, ST_R_SET, ST_MUL_RD,
        ST_Z_ADD, ST_WR_Z, ST_MUL_RC, ST_EM, ST_MUL_EF, ST_EF_SET,
        ST_EF_ADD, ST_NEXT, ST_DONE
    } t_state;

    function automatic logic [63:0] f_mag(input logic signed [63:0] a);
        f_mag = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] f_sat(input logic neg, input logic over,
                                                 input logic [63:0] m);
        if (!neg) begin
            f_sat = (over || m[63]) ? SMAX : $signed(m);
        end else begin
            f_sat = (over || m[63]) ? SMIN : $signed(64'd0 - m);
        end
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            f_sadd = s[64] ? SMIN : SMAX;
        end else begin
            f_sadd = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] f_ssub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            f_ssub = s[64] ? SMIN : SMAX;
        end else begin
            f_ssub = s[63:0];
        end
    endfunction

endpackage

FILE: design/nose_hoover_chain_update.sv
// nose-hoover chain thermostat update, top level with config and output registers
// the time from input transfer to output valid grows with the number of active links,
// set by the shared bit serial divider (q.24 quotients, and an integer quotient for the
// first link) and the iterative multiplier, plus any output stall
// one item in flight at a time: no new input until the result is in the output register
// synchronous active-low reset: config to defaults, chain state reads as zero
module nose_hoover_chain_update
    import nhc_pkg::*;
#(
    parameter int MAX_LINKS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [46:0]        i_measured_kt,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_momentum_energy,
    output logic signed [63:0] o_friction_energy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [46:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_LINKS);
    localparam int LW = $clog2(MAX_LINKS + 1);

    t_cfg       r_cfg;
    logic [3:0] r_active;
    logic [LW-1:0] w_links;

    logic       r_ovalid;
    logic signed [63:0] r_me, r_fe;

    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic [AW-1:0] w_addr;
    logic       w_busy, w_push, w_out_free;
    logic signed [63:0] w_em, w_ef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_kt          <= 47'd16777216;
            r_cfg.coupling_freq      <= '0;
            r_cfg.time_step          <= 32'd16777216;
            r_cfg.degrees_of_freedom <= 24'd3;
            r_active                 <= 4'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_KT:    r_cfg.target_kt          <= i_cfg_data;
                CFG_COUPLING:     r_cfg.coupling_freq      <= i_cfg_data[24:0];
                CFG_TIME_STEP:    r_cfg.time_step          <= i_cfg_data[31:0];
                CFG_DOF:          r_cfg.degrees_of_freedom <= i_cfg_data[23:0];
                CFG_ACTIVE_LINKS: r_active                 <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_active < 4'd2) begin
            w_links = LW'(2);
        end else if (32'(r_active) > MAX_LINKS) begin
            w_links = LW'(MAX_LINKS);
        end else begin
            w_links = LW'(r_active);
        end
    end

    assign w_out_free = !r_ovalid || !i_stall;

    nhc_ctrl #(
        .MAX_LINKS (MAX_LINKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (w_out_free),
        .i_links    (w_links),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .o_busy     (w_busy),
        .o_push     (w_push)
    );

    nhc_datapath #(
        .MAX_LINKS (MAX_LINKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_measured_kt (i_measured_kt),
        .i_cmd         (w_cmd),
        .i_addr        (w_addr),
        .o_sts         (w_sts),
        .o_em          (w_em),
        .o_ef          (w_ef)
    );

    // result register, freed by an output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_push) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_me <= w_em;
            r_fe <= w_ef;
        end
    end

    assign o_stall           = w_busy;
    assign o_valid           = r_ovalid;
    assign o_momentum_energy = r_me;
    assign o_friction_energy = r_fe;
    assign o_cfg_ready       = !w_busy;

endmodule

FILE: design/nhc_mul.sv
// iterative q40.24 multiplier, four 32x32 partial products
module nhc_mul
    import nhc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic signed [63:0] r_res;

    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_sh;

    assign w_ah = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_bh = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_pp = w_ah * w_bh;

    always_comb begin
        case ({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]})
            2'd0:    w_pp_sh = {64'd0, w_pp};
            2'd1:    w_pp_sh = {32'd0, w_pp, 32'd0};
            default: w_pp_sh = {w_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt[2]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= f_mag(i_a);
            r_ub  <= f_mag(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy && !r_cnt[2]) begin
            r_acc <= r_acc + w_pp_sh;
        end else if (r_busy) begin
            r_res <= f_sat(r_neg, |r_acc[127:88], r_acc[87:24]);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: design/nhc_div.sv
// bit serial restoring divider for q.24 and integer quotients
module nhc_div
    import nhc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic [46:0]        i_b,
    input  logic               i_frac,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic [87:0] r_num;
    logic [46:0] r_rem;
    logic [46:0] r_b;
    logic [63:0] r_q;
    logic        r_over, r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic signed [63:0] r_res;

    logic [47:0] w_rem_sh;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_num[87]};
    assign w_ge     = w_rem_sh >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_frac ? 7'd88 : 7'd64;
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {f_mag(i_a), 24'd0};
            r_rem  <= '0;
            r_b    <= i_b;
            r_q    <= '0;
            r_over <= 1'b0;
            r_neg  <= i_a[63];
        end else if (r_busy && r_cnt != 7'd0) begin
            r_num <= {r_num[86:0], 1'b0};
            if (r_q[63]) begin
                r_over <= 1'b1;
            end
            r_q <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? 47'(w_rem_sh - {1'b0, r_b}) : w_rem_sh[46:0];
        end else if (r_busy) begin
            r_res <= f_sat(r_neg, r_over, r_q);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: design/nhc_datapath.sv
// chain state memories, operand registers, multiplier and divider
module nhc_datapath
    import nhc_pkg::*;
#(
    parameter int MAX_LINKS = 8,
    parameter int AW        = $clog2(MAX_LINKS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic [46:0]        i_measured_kt,
    input  t_dp_cmd            i_cmd,
    input  logic [AW-1:0]      i_addr,
    output t_dp_sts            o_sts,
    output logic signed [63:0] o_em,
    output logic signed [63:0] o_ef
);

    logic signed [63:0] r_mem_c [MAX_LINKS];
    logic signed [63:0] r_mem_z [MAX_LINKS];
    logic [MAX_LINKS-1:0] r_cvld, r_zvld;
    logic signed [63:0] r_rdc, r_rdz;

    logic [46:0] r_kt;
    logic [25:0] r_w2;
    logic signed [63:0] r_ci, r_cn, r_p, r_f, r_r, r_z, r_em, r_ef;

    logic [46:0] w_tgt;
    logic [23:0] w_dof;
    logic [49:0] w_cf2;
    logic signed [63:0] w_t, w_ktt, w_dq, w_dt, w_w2;
    logic signed [63:0] w_mul_a, w_mul_b, w_div_a, w_mul_res, w_div_res;
    logic [46:0] w_div_b;
    logic w_mul_done, w_div_done;

    assign w_tgt = (i_cfg.target_kt == '0) ? 47'd1 : i_cfg.target_kt;
    assign w_dof = (i_cfg.degrees_of_freedom == '0) ? 24'd1 : i_cfg.degrees_of_freedom;
    assign w_cf2 = i_cfg.coupling_freq * i_cfg.coupling_freq;
    assign w_t   = $signed({17'd0, w_tgt});
    assign w_ktt = $signed({17'd0, r_kt}) - w_t;
    assign w_dq  = $signed({16'd0, w_dof, 24'd0});
    assign w_dt  = $signed({32'd0, i_cfg.time_step});
    assign w_w2  = $signed({38'd0, r_w2});

    always_comb begin
        case (i_cmd.mul_a)
            OPD_KTT: w_mul_a = w_ktt;
            OPD_DQ:  w_mul_a = w_dq;
            OPD_CI:  w_mul_a = r_ci;
            OPD_CN:  w_mul_a = r_cn;
            OPD_P:   w_mul_a = r_p;
            OPD_W2:  w_mul_a = w_w2;
            OPD_DT:  w_mul_a = w_dt;
            OPD_F:   w_mul_a = r_f;
            OPD_R:   w_mul_a = r_r;
            OPD_Z:   w_mul_a = r_z;
            default: w_mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.mul_b)
            OPD_KTT: w_mul_b = w_ktt;
            OPD_DQ:  w_mul_b = w_dq;
            OPD_CI:  w_mul_b = r_ci;
            OPD_CN:  w_mul_b = r_cn;
            OPD_P:   w_mul_b = r_p;
            OPD_W2:  w_mul_b = w_w2;
            OPD_DT:  w_mul_b = w_dt;
            OPD_F:   w_mul_b = r_f;
            OPD_R:   w_mul_b = r_r;
            OPD_Z:   w_mul_b = r_z;
            default: w_mul_b = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.div_a)
            OPD_CI:  w_div_a = r_ci;
            OPD_P:   w_div_a = r_p;
            default: w_div_a = r_r;
        endcase
    end

    assign w_div_b = (i_cmd.div_b == DSR_TGT) ? w_tgt : {23'd0, w_dof};

    nhc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    nhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .i_frac  (i_cmd.div_b == DSR_TGT),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // valid bits stand in for the zero reset of the chain memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_zvld <= '0;
        end else begin
            if (i_cmd.wr_c) begin
                r_cvld[i_addr] <= 1'b1;
            end
            if (i_cmd.wr_z) begin
                r_zvld[i_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_c) begin
            r_mem_c[i_addr] <= r_ci;
        end
        if (i_cmd.wr_z) begin
            r_mem_z[i_addr] <= r_z;
        end
        if (i_cmd.rd) begin
            r_rdc <= r_cvld[i_addr] ? r_mem_c[i_addr] : '0;
            r_rdz <= r_zvld[i_addr] ? r_mem_z[i_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w2 <= w_cf2[49:24];
        if (i_cmd.kt_load) begin
            r_kt <= i_measured_kt;
        end
        if (w_mul_done) begin
            r_p <= w_mul_res;
        end else if (w_div_done) begin
            r_p <= w_div_res;
        end
        if (i_cmd.ld_ci) begin
            r_ci <= r_rdc;
        end
        if (i_cmd.ld_cn) begin
            r_cn <= r_rdc;
        end
        if (i_cmd.ld_z) begin
            r_z <= r_rdz;
        end
        case (i_cmd.alu)
            ALU_F_SET:  r_f  <= r_p;
            ALU_F_RT:   r_f  <= f_ssub(r_r, w_t);
            ALU_F_SUB:  r_f  <= f_ssub(r_f, r_p);
            ALU_CI_ADD: r_ci <= f_sadd(r_ci, r_p);
            ALU_R_SET:  r_r  <= r_p;
            ALU_Z_ADD:  r_z  <= f_sadd(r_z, r_p);
            ALU_EM_SET: begin
                r_em <= r_p;
                r_r  <= r_p;
            end
            ALU_EM_ADD: begin
                r_em <= f_sadd(r_em, r_p);
                r_r  <= r_p;
            end
            ALU_EF_SET: r_ef <= r_p;
            ALU_EF_ADD: r_ef <= f_sadd(r_ef, r_z);
            default: ;
        endcase
    end

    assign o_sts.mul_done = w_mul_done;
    assign o_sts.div_done = w_div_done;
    assign o_em = r_em;
    assign o_ef = r_ef;

endmodule

FILE: design/nhc_ctrl.sv
// sequencer that walks the chain links one micro step at a time
`include "nose_hoover_chain_update_assert.svh"

module nhc_ctrl
    import nhc_pkg::*;
#(
    parameter int MAX_LINKS = 8,
    parameter int AW        = $clog2(MAX_LINKS),
    parameter int LW        = $clog2(MAX_LINKS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_free,
    input  logic [LW-1:0] i_links,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_addr,
    output logic          o_busy,
    output logic          o_push
);

    t_state r_state, n_state;
    logic   r_first;
    logic [AW-1:0] r_idx, n_idx;
    logic   w_first_link, w_more;

    assign w_first_link = (r_idx == '0);
    assign w_more       = (LW'(r_idx) + LW'(2)) < i_links;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_RDC;
            ST_RDC:    n_state = ST_LDC;
            ST_LDC:    n_state = ST_LDN;
            ST_LDN:    n_state = w_first_link ? ST_MUL_KD : ST_F_RT;
            ST_MUL_KD: if (i_sts.mul_done) n_state = ST_F_SET;
            ST_F_SET:  n_state = ST_MUL_CC;
            ST_F_RT:   n_state = ST_MUL_CC;
            ST_MUL_CC: if (i_sts.mul_done) n_state = ST_DIV_PT;
            ST_DIV_PT: if (i_sts.div_done) n_state = ST_MUL_PW;
            ST_MUL_PW: if (i_sts.mul_done) n_state = ST_F_SUB;
            ST_F_SUB:  n_state = ST_MUL_DF;
            ST_MUL_DF: if (i_sts.mul_done) n_state = ST_CI_ADD;
            ST_CI_ADD: n_state = ST_WR_C;
            ST_WR_C:   n_state = ST_DIV_CT;
            ST_DIV_CT: begin
                if (i_sts.div_done) n_state = w_first_link ? ST_DIV_PD : ST_MUL_QW;
            end
            ST_DIV_PD: if (i_sts.div_done) n_state = ST_MUL_QW;
            ST_MUL_QW: if (i_sts.mul_done) n_state = ST_R_SET;
            ST_R_SET:  n_state = ST_MUL_RD;
            ST_MUL_RD: if (i_sts.mul_done) n_state = ST_Z_ADD;
            ST_Z_ADD:  n_state = ST_WR_Z;
            ST_WR_Z:   n_state = ST_MUL_RC;
            ST_MUL_RC: if (i_sts.mul_done) n_state = ST_EM;
            ST_EM:     n_state = w_first_link ? ST_MUL_EF : ST_EF_ADD;
            ST_MUL_EF: if (i_sts.mul_done) n_state = ST_EF_SET;
            ST_EF_SET: n_state = ST_NEXT;
            ST_EF_ADD: n_state = ST_NEXT;
            ST_NEXT: begin
                if (w_more) begin
                    n_state = ST_RDC;
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{mul_start: 1'b0, mul_a: OPD_CI, mul_b: OPD_CI, div_start: 1'b0,
                  div_a: OPD_P, div_b: DSR_TGT, alu: ALU_NONE, rd: 1'b0,
                  ld_ci: 1'b0, ld_cn: 1'b0, ld_z: 1'b0, addr_nxt: 1'b0,
                  wr_c: 1'b0, wr_z: 1'b0, kt_load: 1'b0};
        o_push = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd.kt_load = i_valid;
            ST_RDC:  o_cmd.rd = 1'b1;
            ST_LDC: begin
                o_cmd.ld_ci    = 1'b1;
                o_cmd.ld_z     = 1'b1;
                o_cmd.rd       = 1'b1;
                o_cmd.addr_nxt = 1'b1;
            end
            ST_LDN: o_cmd.ld_cn = 1'b1;
            ST_MUL_KD: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_KTT;
                o_cmd.mul_b     = OPD_DQ;
            end
            ST_F_SET: o_cmd.alu = ALU_F_SET;
            ST_F_RT:  o_cmd.alu = ALU_F_RT;
            ST_MUL_CC: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_CI;
                o_cmd.mul_b     = OPD_CN;
            end
            ST_DIV_PT: begin
                o_cmd.div_start = r_first;
                o_cmd.div_a     = OPD_P;
                o_cmd.div_b     = DSR_TGT;
            end
            ST_MUL_PW, ST_MUL_QW: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_P;
                o_cmd.mul_b     = OPD_W2;
            end
            ST_F_SUB: o_cmd.alu = ALU_F_SUB;
            ST_MUL_DF: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_DT;
                o_cmd.mul_b     = OPD_F;
            end
            ST_CI_ADD: o_cmd.alu = ALU_CI_ADD;
            ST_WR_C:   o_cmd.wr_c = 1'b1;
            ST_DIV_CT: begin
                o_cmd.div_start = r_first;
                o_cmd.div_a     = OPD_CI;
                o_cmd.div_b     = DSR_TGT;
            end
            ST_DIV_PD: begin
                o_cmd.div_start = r_first;
                o_cmd.div_a     = OPD_P;
                o_cmd.div_b     = DSR_DOF;
            end
            ST_R_SET: o_cmd.alu = ALU_R_SET;
            ST_MUL_RD: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_R;
                o_cmd.mul_b     = OPD_DT;
            end
            ST_Z_ADD: o_cmd.alu = ALU_Z_ADD;
            ST_WR_Z:  o_cmd.wr_z = 1'b1;
            ST_MUL_RC: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_R;
                o_cmd.mul_b     = OPD_CI;
            end
            ST_EM: o_cmd.alu = w_first_link ? ALU_EM_SET : ALU_EM_ADD;
            ST_MUL_EF: begin
                o_cmd.mul_start = r_first;
                o_cmd.mul_a     = OPD_DQ;
                o_cmd.mul_b     = OPD_Z;
            end
            ST_EF_SET: o_cmd.alu = ALU_EF_SET;
            ST_EF_ADD: o_cmd.alu = ALU_EF_ADD;
            ST_DONE:   o_push = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b1;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
            r_idx   <= n_idx;
        end
    end

    assign o_addr = o_cmd.addr_nxt ? (r_idx + AW'(1)) : r_idx;
    assign o_busy = (r_state != ST_IDLE);

    `NHC_ASSERT_NEVER(a_one_unit, i_clk, i_rst_n, o_cmd.mul_start && o_cmd.div_start)
    `NHC_ASSERT_IMPLIES(a_done_in_walk, i_clk, i_rst_n, i_sts.mul_done || i_sts.div_done, r_state != ST_IDLE && r_state != ST_DONE)
    `NHC_ASSERT_IMPLIES(a_idx_idle, i_clk, i_rst_n, r_state == ST_IDLE, r_idx == '0)

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the nose-hoover chain thermostat update block
`timescale 1ns / 100ps

module testbench;
    import nhc_pkg::*;

    localparam int MAXL = 8;
    localparam int IDLE_LIMIT = 30000;
    localparam int HOLD_CYCLES = 5000;

    class chain_scoreboard;
        logic [46:0] tgt_kt;
        logic [24:0] coup;
        logic [31:0] dt;
        logic [23:0] dof;
        logic [3:0]  links;
        logic signed [63:0] mom [MAXL];
        logic signed [63:0] pos [MAXL];
        logic signed [63:0] exp_mom_energy [$];
        logic signed [63:0] exp_fric_energy [$];
        int errors;
        int checked;

        function new();
            tgt_kt = 47'd1 << 24;
            coup = '0;
            dt = 32'd1 << 24;
            dof = 24'd3;
            links = 4'd2;
            for (int i = 0; i < MAXL; i++) begin
                mom[i] = '0;
                pos[i] = '0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [46:0] d);
            case (idx)
                CFG_TARGET_KT:    tgt_kt = d;
                CFG_COUPLING:     coup = d[24:0];
                CFG_TIME_STEP:    dt = d[31:0];
                CFG_DOF:          dof = d[23:0];
                CFG_ACTIVE_LINKS: links = d[3:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] absval(logic signed [63:0] a);
            return a[63] ? 64'd0 - a : a;
        endfunction

        function logic signed [63:0] clamp(logic neg, logic over, logic [63:0] m);
            if (!neg) return (over || m[63]) ? SMAX : $signed(m);
            return (over || m[63]) ? SMIN : $signed(64'd0 - m);
        endfunction

        function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
            return s;
        endfunction

        function logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] s;
            s = a - b;
            if (a[63] != b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
            return s;
        endfunction

        function logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] p;
            p = {64'd0, absval(a)} * {64'd0, absval(b)};
            return clamp(a[63] ^ b[63], |p[127:88], p[87:24]);
        endfunction

        function logic signed [63:0] fx_div(logic signed [63:0] a, logic [63:0] b);
            logic [127:0] num;
            logic [127:0] q;
            num = {64'd0, absval(a)} << 24;
            q = num / {64'd0, b};
            return clamp(a[63], |q[127:64], q[63:0]);
        endfunction

        function void note_input(logic [46:0] kt);
            int n;
            logic [63:0] tg, df, sq;
            logic signed [63:0] t, dtv, dq, w2, f, r, q, em, ef;
            n = links < 2 ? 2 : (links > MAXL ? MAXL : int'(links));
            tg = (tgt_kt == 0) ? 64'd1 : {17'd0, tgt_kt};
            df = (dof == 0) ? 64'd1 : {40'd0, dof};
            t = tg;
            dtv = {32'd0, dt};
            dq = df << 24;
            sq = {39'd0, coup} * {39'd0, coup};
            w2 = sq >> 24;
            f = fx_mul($signed({17'd0, kt}) - t, dq);
            f = sub_sat(f, fx_mul(fx_div(fx_mul(mom[0], mom[1]), tg), w2));
            mom[0] = add_sat(mom[0], fx_mul(dtv, f));
            q = fx_div(mom[0], tg);
            q = clamp(q[63], 1'b0, absval(q) / df);
            r = fx_mul(q, w2);
            pos[0] = add_sat(pos[0], fx_mul(r, dtv));
            r = fx_mul(r, mom[0]);
            em = r;
            ef = fx_mul(dq, pos[0]);
            for (int i = 1; i + 1 < n; i++) begin
                f = sub_sat(r, t);
                f = sub_sat(f, fx_mul(fx_div(fx_mul(mom[i], mom[i+1]), tg), w2));
                mom[i] = add_sat(mom[i], fx_mul(dtv, f));
                r = fx_mul(fx_div(mom[i], tg), w2);
                pos[i] = add_sat(pos[i], fx_mul(r, dtv));
                r = fx_mul(r, mom[i]);
                em = add_sat(em, r);
                ef = add_sat(ef, pos[i]);
            end
            exp_mom_energy.push_back(em);
            exp_fric_energy.push_back(ef);
        endfunction

        function void check_result(logic signed [63:0] em, logic signed [63:0] ef);
            logic signed [63:0] xm, xf;
            if (exp_mom_energy.size() == 0) begin
                $error("result transfer with nothing expected: momentum_energy %0d", em);
                errors++;
                return;
            end
            xm = exp_mom_energy.pop_front();
            xf = exp_fric_energy.pop_front();
            checked++;
            if (em !== xm) begin
                $error("momentum_energy: expected %0d actual %0d", xm, em);
                errors++;
            end
            if (ef !== xf) begin
                $error("friction_energy: expected %0d actual %0d", xf, ef);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [46:0]        i_measured_kt;
    logic               o_valid;
    logic               i_stall;
    logic signed [63:0] o_momentum_energy;
    logic signed [63:0] o_friction_energy;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [46:0]        i_cfg_data;

    chain_scoreboard sb = new();
    logic quiet;
    logic hold_req;
    int   idle_cnt;
    int   items_sent;
    int   cfg_writes;

    nose_hoover_chain_update #(.MAX_LINKS(MAXL)) uut (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_measured_kt);
            if (o_valid && !i_stall) sb.check_result(o_momentum_energy, o_friction_energy);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
            end
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("** nose_hoover_chain_update: FAILED **");
                $finish;
            end
        end
    end

    // receiver side stall pattern
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
        end
    end

    function automatic logic [46:0] rnd47();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[46:0];
    endfunction

    task automatic send_item(logic [46:0] kt);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_measured_kt = kt;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [46:0] d);
        @(negedge i_clk);
        i_valid = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.exp_mom_energy.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_all(logic [46:0] tg, logic [24:0] cf, logic [31:0] step,
                           logic [23:0] nd, logic [3:0] nl);
        write_reg(CFG_TARGET_KT, tg);
        write_reg(CFG_COUPLING, {22'd0, cf});
        write_reg(CFG_TIME_STEP, {15'd0, step});
        write_reg(CFG_DOF, {23'd0, nd});
        write_reg(CFG_ACTIVE_LINKS, {43'd0, nl});
    endtask

    initial begin
        logic [46:0] tg;
        logic [47:0] kt;
        quiet = 1'b0;
        hold_req = 1'b0;
        idle_cnt = 0;
        items_sent = 0;
        cfg_writes = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_measured_kt = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults
        send_item('0);
        send_item({47{1'b1}});
        send_item(47'd1 << 24);
        send_item((47'd1 << 24) + 1);
        send_item((47'd1 << 24) - 1);
        drain();

        set_all(47'd1 << 24, 25'd1 << 22, 32'd1 << 20, 24'd3, 4'd4);
        send_item('0);
        send_item(47'd3 << 24);
        send_item(47'd1 << 23);
        send_item({47{1'b1}});
        send_item(47'h2AAA_AAAA_AAAA);
        drain();

        // extremes
        set_all({47{1'b1}}, 25'd16777216, 32'hFFFF_FFFF, 24'hFF_FFFF, 4'd8);
        send_item('0);
        send_item({47{1'b1}});
        send_item(47'h5555_5555_5555);
        drain();

        // zero target, zero dof, link counts out of range, unknown indexes
        set_all('0, 25'd16777216, 32'd1 << 24, '0, 4'd0);
        write_reg(3'd5, {47{1'b1}});
        write_reg(3'd6, '0);
        write_reg(3'd7, 47'h1234);
        send_item('0);
        send_item(47'd5);
        drain();
        write_reg(CFG_ACTIVE_LINKS, 47'd1);
        send_item(47'd1 << 24);
        drain();
        write_reg(CFG_ACTIVE_LINKS, 47'd15);
        write_reg(CFG_COUPLING, '0);
        write_reg(CFG_TIME_STEP, '0);
        send_item({47{1'b1}});
        drain();
        write_reg(CFG_ACTIVE_LINKS, 47'd9);
        write_reg(CFG_TIME_STEP, 47'd1 << 24);
        send_item(47'd7 << 24);
        drain();

        for (int p = 0; p < 13; p++) begin
            tg = ($urandom_range(0, 1)) ? (47'($urandom_range(1, 16)) << 24) : rnd47();
            set_all(tg, 25'($urandom_range(0, 16777216)),
                    $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 26)) : $urandom,
                    $urandom_range(0, 1) ? 24'($urandom_range(1, 64)) : 24'($urandom),
                    (p % 5 == 4) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(2, 4)));
            quiet = (p == 2);
            if (p == 5) hold_req = 1'b1;
            for (int k = 0; k < 66; k++) begin
                if ($urandom_range(0, 99) < 60) begin
                    kt = {1'b0, tg} + 48'($urandom_range(0, 1 << 25)) - 48'd1 * (1 << 24);
                    if (kt[47]) kt = '0;
                    send_item(kt[46:0]);
                end else begin
                    send_item(rnd47());
                end
            end
            drain();
            quiet = 1'b0;
        end

        $display("ran %0d steps over %0d register writes, %0d results checked",
                 items_sent, cfg_writes, sb.checked);
        if (sb.errors == 0 && sb.exp_mom_energy.size() == 0) begin
            $display("** nose_hoover_chain_update: PASSED **");
        end else begin
            $display("** nose_hoover_chain_update: FAILED **");
        end
        $finish;
    end

endmodule
